>>> hw/rtl/button_press_classifier_macros.svh
// Assertion macros used by the button press classifier checker.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define BPC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("button press classifier check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define BPC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("button press classifier check failed");

`endif

>>> hw/rtl/bpc_pkg.sv
// Package with types, codes and constants of the button press classifier.
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

   localparam int NUM_BUTTONS_DEF = 16;
   localparam int TIME_BITS_DEF   = 16;
   localparam int MAX_FACTOR      = 10;
   localparam int CSR_ADDR_W      = 4;
   localparam int CSR_DATA_W      = 32;

   localparam logic [2:0] CLS_NONE = 3'd0;
   localparam logic [2:0] CLS_REL  = 3'd1;
   localparam logic [2:0] CLS_SCLK = 3'd2;
   localparam logic [2:0] CLS_SPRS = 3'd3;
   localparam logic [2:0] CLS_LCLK = 3'd4;
   localparam logic [2:0] CLS_LPRS = 3'd5;
   localparam logic [2:0] CLS_RPT  = 3'd6;

   localparam logic [1:0] REG_LONG_PRESS  = 2'd0;
   localparam logic [1:0] REG_REPEAT      = 2'd1;
   localparam logic [1:0] REG_SWITCH_MASK = 2'd2;

   localparam logic [11:0] LONG_PRESS_RST = 12'd500;
   localparam logic [11:0] REPEAT_RST     = 12'd200;
   localparam logic [15:0] SWITCH_RST     = 16'd0;

   typedef struct packed {
      logic [11:0] long_press_ticks;
      logic [11:0] repeat_ticks;
      logic [15:0] switch_mask;
   } bpc_cfg_type;

   typedef struct packed {
      logic clicked;
      logic long_clicked;
      logic short_released;
      logic released;
      logic clicking;
      logic pressed;
      logic long_pressed;
   } bpc_flags_type;

endpackage
`default_nettype wire

>>> hw/rtl/bpc_if.sv
// Valid/ready channel interfaces for the sample items and the result items.
`timescale 1ns / 1ps
`default_nettype none
interface bpc_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] button;
   logic       level;
   logic [9:0] elapsed;
   logic       action;

   modport source (output valid, button, level, elapsed, action, input ready);
   modport sink (input valid, button, level, elapsed, action, output ready);
endinterface

interface bpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  which_button;
   logic [2:0]  press_class;
   logic [15:0] held_ticks;
   logic        clicked;
   logic        long_clicked;
   logic        short_released;
   logic        released;
   logic        clicking;
   logic        pressed;
   logic        long_pressed;

   modport source (output valid, which_button, press_class, held_ticks, clicked,
                   long_clicked, short_released, released, clicking, pressed,
                   long_pressed, input ready);
   modport sink (input valid, which_button, press_class, held_ticks, clicked,
                 long_clicked, short_released, released, clicking, pressed,
                 long_pressed, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/bpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bpc_csr.sv
// APB-style configuration registers of the button press classifier.
`timescale 1ns / 1ps
`default_nettype none
module bpc_csr
   import bpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output bpc_cfg_type                cfg
);

   logic [11:0] long_press_ff;
   logic [11:0] repeat_ff;
   logic [15:0] switch_mask_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff  <= LONG_PRESS_RST;
         repeat_ff      <= REPEAT_RST;
         switch_mask_ff <= SWITCH_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_LONG_PRESS:  long_press_ff  <= csr_pwdata[11:0];
            REG_REPEAT:      repeat_ff      <= csr_pwdata[11:0];
            REG_SWITCH_MASK: switch_mask_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_LONG_PRESS:  csr_prdata = CSR_DATA_W'(long_press_ff);
         REG_REPEAT:      csr_prdata = CSR_DATA_W'(repeat_ff);
         REG_SWITCH_MASK: csr_prdata = CSR_DATA_W'(switch_mask_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.long_press_ticks = long_press_ff;
   assign cfg.repeat_ticks     = repeat_ff;
   assign cfg.switch_mask      = switch_mask_ff;

endmodule
`default_nettype wire

>>> hw/rtl/bpc_update.sv
// Next class and press time of one button, and the result flags.
`timescale 1ns / 1ps
`default_nettype none
module bpc_update
   import bpc_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire bpc_cfg_type           cfg,
   input  wire logic [3:0]            button,
   input  wire logic                  level,
   input  wire logic [9:0]            elapsed,
   input  wire logic                  action,
   input  wire logic [2:0]            cls_cur,
   input  wire logic [TIME_BITS-1:0]  time_cur,
   output logic      [2:0]            cls_nxt,
   output logic      [TIME_BITS-1:0]  time_nxt,
   output bpc_flags_type              flags
);

   localparam int CW = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

   logic [TIME_BITS:0]   sum;
   logic [TIME_BITS-1:0] t_add;
   logic [CW-1:0]        lpt;
   logic [CW-1:0]        lpt_max;
   logic [CW-1:0]        lpt_rpt;
   logic [CW-1:0]        t_cur_w;
   logic [CW-1:0]        t_add_w;
   logic [CW-1:0]        t_nxt_w;
   logic                 is_switch;

   assign lpt       = CW'(cfg.long_press_ticks);
   assign lpt_max   = lpt * CW'(MAX_FACTOR);
   assign lpt_rpt   = lpt + CW'(cfg.repeat_ticks);
   assign t_cur_w   = CW'(time_cur);
   assign sum       = {1'b0, time_cur} + (TIME_BITS + 1)'(elapsed);
   assign is_switch = cfg.switch_mask[button];

   always_comb begin
      if (t_cur_w < lpt_max) begin
         t_add = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
      end else begin
         t_add = time_cur;
      end
   end

   assign t_add_w = CW'(t_add);

   always_comb begin
      cls_nxt  = cls_cur;
      time_nxt = time_cur;
      if (action) begin
         cls_nxt  = CLS_NONE;
         time_nxt = '0;
      end else if (is_switch) begin
         cls_nxt = level ? CLS_SPRS : CLS_NONE;
      end else if (!level) begin
         if (cls_cur[2:1] != 2'b00) begin
            cls_nxt = CLS_REL;
         end else begin
            cls_nxt  = CLS_NONE;
            time_nxt = '0;
         end
      end else begin
         time_nxt = t_add;
         if (cls_cur == CLS_NONE) begin
            cls_nxt = CLS_SCLK;
         end else if ((cls_cur == CLS_SCLK || cls_cur == CLS_SPRS) && t_add_w < lpt) begin
            cls_nxt = CLS_SPRS;
         end else if (cls_cur == CLS_SPRS) begin
            cls_nxt = CLS_LCLK;
         end else if (cls_cur inside {CLS_LCLK, CLS_LPRS, CLS_RPT}) begin
            if (t_add_w >= lpt_rpt) begin
               cls_nxt  = CLS_RPT;
               time_nxt = t_add - TIME_BITS'(cfg.repeat_ticks);
            end else begin
               cls_nxt = CLS_LPRS;
            end
         end else begin
            cls_nxt  = CLS_NONE;
            time_nxt = '0;
         end
      end
   end

   assign t_nxt_w = CW'(time_nxt);

   assign flags.clicked        = (cls_nxt == CLS_SCLK);
   assign flags.long_clicked   = (cls_nxt == CLS_LCLK);
   assign flags.released       = (cls_nxt == CLS_REL);
   assign flags.short_released = (cls_nxt == CLS_REL) && (t_nxt_w < lpt);
   assign flags.clicking       = (cls_nxt == CLS_SCLK) || (cls_nxt == CLS_LCLK) ||
                                 (cls_nxt == CLS_RPT);
   assign flags.pressed        = (cls_nxt > CLS_REL);
   assign flags.long_pressed   = (cls_nxt > CLS_REL) && (t_nxt_w > lpt);

endmodule
`default_nettype wire

>>> hw/rtl/button_press_classifier.sv
// Top level of the button press classifier.
//
//   channel  | dir | handshake          | item
//   req_chan | in  | valid/ready        | button, level, elapsed, action
//   rsp_chan | out | valid/ready        | which_button, press_class, held_ticks, flags
//   csr_*    | in  | APB, pready high   | long_press_ticks, repeat_ticks, switch_mask
//
// One item is accepted per cycle unless a stalled result holds req_chan.ready low; the item
// is held in the input stage and its result in the output register. The state RAM read is
// issued at acceptance, and the write-back goes with the result register when the input stage
// advances; a forward path covers an item that follows one for the same button.
// Reset clears the pipeline valid bits, the configuration registers and the per-button valid bits at once.
// A stalled result holds in the output register while one more item waits in the
// input stage; further items are held off by req_chan.ready.
`timescale 1ns / 1ps
`default_nettype none
module button_press_classifier
   import bpc_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF,
   parameter int TIME_BITS   = TIME_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   bpc_req_if.sink                    req_chan,
   bpc_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
   localparam int DW    = 3 + TIME_BITS;
   localparam int HW    = (TIME_BITS > 16) ? TIME_BITS : 16;

   bpc_cfg_type   cfg;
   bpc_flags_type flags;

   logic                 accept;
   logic                 s1_adv;
   logic                 req_in_range;
   logic [IDX_W+3:0]     req_idx_wide;
   logic [IDX_W-1:0]     req_idx;
   logic [IDX_W-1:0]     s1_idx;
   logic                 wr_en;
   logic [DW-1:0]        wr_data;
   logic [DW-1:0]        rd_data;
   logic [2:0]           cls_cur;
   logic [TIME_BITS-1:0] time_cur;
   logic [2:0]           cls_nxt;
   logic [TIME_BITS-1:0] time_nxt;
   logic [HW-1:0]        time_wide;

   logic                 s1_valid_ff;
   logic [3:0]           s1_button_ff;
   logic                 s1_level_ff;
   logic [9:0]           s1_elapsed_ff;
   logic                 s1_action_ff;
   logic                 s1_in_range_ff;
   logic                 s1_entry_vld_ff;
   logic                 s1_byp_ff;
   logic [DW-1:0]        s1_byp_data_ff;
   logic [NUM_BUTTONS-1:0] entry_vld_ff;

   logic                 rsp_valid_ff;
   logic [3:0]           rsp_button_ff;
   logic [2:0]           rsp_class_ff;
   logic [15:0]          rsp_held_ff;
   bpc_flags_type        rsp_flags_ff;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_idx_wide = (IDX_W + 4)'(req_chan.button);
   assign req_idx      = req_idx_wide[IDX_W-1:0];
   assign req_in_range = 7'(req_chan.button) < 7'(NUM_BUTTONS);

   logic [IDX_W+3:0] s1_idx_wide;
   assign s1_idx_wide = (IDX_W + 4)'(s1_button_ff);
   assign s1_idx      = s1_idx_wide[IDX_W-1:0];

   assign wr_en   = s1_adv && s1_in_range_ff;
   assign wr_data = {cls_nxt, time_nxt};

   bpc_ram #(
      .WIDTH (DW),
      .DEPTH (NUM_BUTTONS)
   ) u_state_ram (
      .clock (clock),
      .we    (wr_en),
      .waddr (s1_idx),
      .wdata (wr_data),
      .re    (accept),
      .raddr (req_idx),
      .rdata (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         entry_vld_ff <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (wr_en) begin
            entry_vld_ff[s1_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_button_ff    <= req_chan.button;
         s1_level_ff     <= req_chan.level;
         s1_elapsed_ff   <= req_chan.elapsed;
         s1_action_ff    <= req_chan.action;
         s1_in_range_ff  <= req_in_range;
         s1_entry_vld_ff <= req_in_range && entry_vld_ff[req_idx];
         s1_byp_ff       <= wr_en && (s1_idx == req_idx);
         s1_byp_data_ff  <= wr_data;
      end
   end

   always_comb begin
      if (s1_byp_ff) begin
         {cls_cur, time_cur} = s1_byp_data_ff;
      end else if (s1_entry_vld_ff) begin
         {cls_cur, time_cur} = rd_data;
      end else begin
         cls_cur  = CLS_NONE;
         time_cur = '0;
      end
   end

   bpc_update #(
      .TIME_BITS (TIME_BITS)
   ) u_update (
      .cfg      (cfg),
      .button   (s1_button_ff),
      .level    (s1_level_ff),
      .elapsed  (s1_elapsed_ff),
      .action   (s1_action_ff),
      .cls_cur  (cls_cur),
      .time_cur (time_cur),
      .cls_nxt  (cls_nxt),
      .time_nxt (time_nxt),
      .flags    (flags)
   );

   assign time_wide = HW'(time_nxt);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_button_ff <= s1_button_ff;
         if (s1_in_range_ff) begin
            rsp_class_ff <= cls_nxt;
            rsp_held_ff  <= time_wide[15:0];
            rsp_flags_ff <= flags;
         end else begin
            rsp_class_ff <= CLS_NONE;
            rsp_held_ff  <= '0;
            rsp_flags_ff <= '0;
         end
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.which_button   = rsp_button_ff;
   assign rsp_chan.press_class    = rsp_class_ff;
   assign rsp_chan.held_ticks     = rsp_held_ff;
   assign rsp_chan.clicked        = rsp_flags_ff.clicked;
   assign rsp_chan.long_clicked   = rsp_flags_ff.long_clicked;
   assign rsp_chan.short_released = rsp_flags_ff.short_released;
   assign rsp_chan.released       = rsp_flags_ff.released;
   assign rsp_chan.clicking       = rsp_flags_ff.clicking;
   assign rsp_chan.pressed        = rsp_flags_ff.pressed;
   assign rsp_chan.long_pressed   = rsp_flags_ff.long_pressed;

endmodule
`default_nettype wire

>>> hw/rtl/bpc_checker.sv
// Port-level checker of the button press classifier and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
`include "button_press_classifier_macros.svh"
module bpc_checker
   import bpc_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [3:0]  which_button,
   input wire logic [2:0]  press_class,
   input wire logic [15:0] held_ticks,
   input wire logic        long_clicked,
   input wire logic        clicking,
   input wire logic        pressed,
   input wire logic        released
);

   logic out_of_range;

   assign out_of_range = 7'(which_button) >= 7'(NUM_BUTTONS);

   `BPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BPC_ASSERT_IMPL(a_rsp_from_item, clock, reset, $rose(rsp_valid),
                    $past(req_valid && req_ready, 2))
   `BPC_ASSERT_IMPL(a_range_zero, clock, reset, rsp_valid && out_of_range,
                    press_class == CLS_NONE && held_ticks == 16'd0 && !pressed)
   `BPC_ASSERT_IMPL(a_flag_consistent, clock, reset, rsp_valid && long_clicked,
                    clicking && pressed && !released)

endmodule

bind button_press_classifier bpc_checker #(
   .NUM_BUTTONS (NUM_BUTTONS)
) u_bpc_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_chan.valid),
   .req_ready    (req_chan.ready),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .which_button (rsp_chan.which_button),
   .press_class  (rsp_chan.press_class),
   .held_ticks   (rsp_chan.held_ticks),
   .long_clicked (rsp_chan.long_clicked),
   .clicking     (rsp_chan.clicking),
   .pressed      (rsp_chan.pressed),
   .released     (rsp_chan.released)
);
`default_nettype wire
